// ----- design/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types, constants and helper functions of the palette dither block.
// ----------------------------------------------------------------------------
package ped_pkg;

    localparam int MAX_WIDTH     = 1024;
    localparam int PALETTE_DEPTH = 256;
    localparam int LOOKAHEAD     = 3;
    localparam int SLOTS         = LOOKAHEAD * MAX_WIDTH;
    localparam int COL_W         = $clog2(MAX_WIDTH);
    localparam int SLOT_AW       = $clog2(SLOTS);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int NTAPS         = 12;
    localparam int JJN_RECIP     = 1366;

    typedef enum logic [2:0] {
        MODE_NONE,
        MODE_FS,
        MODE_ATKINSON,
        MODE_JJN,
        MODE_BURKES,
        MODE_SIERRA,
        MODE_SIERRA_LITE
    } mode_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_MODE,
        REG_WIDTH,
        REG_HEIGHT,
        REG_PSIZE
    } reg_idx_t;

    // index 0 red, 1 green, 2 blue
    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic signed [9:0] shift;
        logic [7:0]        low;
        logic [7:0]        high;
    } xform_t;

    typedef struct packed {
        logic signed [2:0] dx;
        logic [1:0]        dy;
        logic [3:0]        w;
    } tap_t;

    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] addr;
        rgb_t              color;
    } pal_wr_t;

    typedef struct packed {
        logic       start;
        logic [8:0] count;
        rgb_t       target;
    } search_req_t;

    typedef struct packed {
        logic              done;
        logic [PAL_AW-1:0] index;
        rgb_t              color;
    } search_res_t;

    localparam xform_t XF_IDENT = '{shift: 10'sd0, low: 8'd0, high: 8'd255};
    localparam tap_t   TZ       = '{dx: 3'sd0, dy: 2'd0, w: 4'd0};

    localparam logic [3:0] TAP_COUNT [7] = '{4'd0, 4'd4, 4'd6, 4'd12, 4'd7, 4'd10, 4'd3};

    localparam tap_t TAPS [7][NTAPS] = '{
        '{TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ},
        '{'{3'sd1, 2'd0, 4'd7}, '{-3'sd1, 2'd1, 4'd3}, '{3'sd0, 2'd1, 4'd5},
          '{3'sd1, 2'd1, 4'd1}, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ},
        '{'{3'sd1, 2'd0, 4'd1}, '{3'sd2, 2'd0, 4'd1}, '{-3'sd1, 2'd1, 4'd1},
          '{3'sd0, 2'd1, 4'd1}, '{3'sd1, 2'd1, 4'd1}, '{3'sd0, 2'd2, 4'd1},
          TZ, TZ, TZ, TZ, TZ, TZ},
        '{'{3'sd1, 2'd0, 4'd7}, '{3'sd2, 2'd0, 4'd5}, '{-3'sd2, 2'd1, 4'd3},
          '{-3'sd1, 2'd1, 4'd5}, '{3'sd0, 2'd1, 4'd7}, '{3'sd1, 2'd1, 4'd5},
          '{3'sd2, 2'd1, 4'd3}, '{-3'sd2, 2'd2, 4'd1}, '{-3'sd1, 2'd2, 4'd3},
          '{3'sd0, 2'd2, 4'd5}, '{3'sd1, 2'd2, 4'd3}, '{3'sd2, 2'd2, 4'd1}},
        '{'{3'sd1, 2'd0, 4'd8}, '{3'sd2, 2'd0, 4'd4}, '{-3'sd2, 2'd1, 4'd2},
          '{-3'sd1, 2'd1, 4'd4}, '{3'sd0, 2'd1, 4'd8}, '{3'sd1, 2'd1, 4'd4},
          '{3'sd2, 2'd1, 4'd2}, TZ, TZ, TZ, TZ, TZ},
        '{'{3'sd1, 2'd0, 4'd5}, '{3'sd2, 2'd0, 4'd3}, '{-3'sd2, 2'd1, 4'd2},
          '{-3'sd1, 2'd1, 4'd4}, '{3'sd0, 2'd1, 4'd5}, '{3'sd1, 2'd1, 4'd4},
          '{3'sd2, 2'd1, 4'd2}, '{-3'sd1, 2'd2, 4'd2}, '{3'sd0, 2'd2, 4'd3},
          '{3'sd1, 2'd2, 4'd2}, TZ, TZ},
        '{'{3'sd1, 2'd0, 4'd2}, '{-3'sd1, 2'd1, 4'd1}, '{3'sd0, 2'd1, 4'd1},
          TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ, TZ}
    };

    function automatic tap_t ped_tap(input mode_t mode, input logic [3:0] k);
        tap_t t;
        t = TZ;
        if (k < 4'(NTAPS) && mode != MODE_NONE)
        begin
            t = TAPS[mode][k];
        end
        return t;
    endfunction

    function automatic logic [3:0] ped_tap_count(input mode_t mode);
        return TAP_COUNT[mode];
    endfunction

    // clamp(raw + shift, low, high)
    function automatic logic [7:0] ped_apply(input logic [7:0] raw, input xform_t x);
        logic signed [10:0] s;
        logic [7:0]         v;
        s = $signed({3'b000, raw}) + 11'(x.shift);
        if (s < $signed({3'b000, x.low}))
        begin
            v = x.low;
        end
        else if (s > $signed({3'b000, x.high}))
        begin
            v = x.high;
        end
        else
        begin
            v = s[7:0];
        end
        return v;
    endfunction

    function automatic logic [7:0] ped_clamp8(input logic signed [10:0] s);
        logic [7:0] v;
        if (s < 11'sd0)
        begin
            v = 8'd0;
        end
        else if (s > 11'sd255)
        begin
            v = 8'd255;
        end
        else
        begin
            v = s[7:0];
        end
        return v;
    endfunction

    function automatic xform_t ped_compose(input xform_t x, input logic signed [8:0] d);
        xform_t             r;
        logic signed [10:0] sh;
        sh = 11'(x.shift) + 11'(d);
        if (sh < -11'sd256)
        begin
            r.shift = -10'sd256;
        end
        else if (sh > 11'sd256)
        begin
            r.shift = 10'sd256;
        end
        else
        begin
            r.shift = sh[9:0];
        end
        r.low  = ped_clamp8($signed({3'b000, x.low}) + 11'(d));
        r.high = ped_clamp8($signed({3'b000, x.high}) + 11'(d));
        return r;
    endfunction

    // weighted error over the kernel divisor, truncated toward zero
    function automatic logic signed [8:0] ped_div(input logic signed [12:0] p,
                                                 input mode_t mode);
        logic [11:0] mag;
        logic [11:0] q;
        logic [23:0] pr;
        mag = p[12] ? 12'(-p) : p[11:0];
        pr  = 24'(mag) * 24'(JJN_RECIP);
        unique case (mode)
            MODE_FS:          q = mag >> 4;
            MODE_ATKINSON:    q = mag >> 3;
            MODE_JJN:         q = 12'(pr >> 16);
            MODE_BURKES:      q = mag >> 5;
            MODE_SIERRA:      q = mag >> 5;
            MODE_SIERRA_LITE: q = mag >> 2;
            default:          q = mag;
        endcase
        return p[12] ? 9'(-$signed({1'b0, q})) : 9'(q);
    endfunction

endpackage

// ----- design/palette_error_diffusion_dither.sv -----
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither
// Error-diffusion ditherer onto a loadable palette of up to 256 colours.
//
//   channel  direction  handshake           payload
//   in       to block   in_valid/in_stall   operation entry_index red green
//                                           blue alpha
//   out      from block out_valid/out_stall color_index out_red out_green
//                                           out_blue out_alpha frame_end
//   cfg      to block   cfg_write           cfg_index cfg_data
//
// a load item writes the palette; the block stays idle. a pixel item searches
// n entries, n the palette size (one entry a cycle through the search pipe),
// then walks the k taps of the kernel, reading and writing the pending store
// (one port each) for the taps inside the image. after reset and after each
// frame's last pixel a pass resets all 3072 pending slots, with in_stall high.
// a result waits in the output register while the block goes on; a pixel
// whose result slot is still full waits before storing its result.
// ----------------------------------------------------------------------------
module palette_error_diffusion_dither
    import ped_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  entry_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  color_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic        frame_end,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_APPLY,
        ST_SEARCH,
        ST_EMIT,
        ST_TAP_RD,
        ST_TAP_WR,
        ST_ADVANCE
    } state_t;

    state_t             state_reg;
    logic [SLOT_AW-1:0] clr_addr_reg;
    logic [COL_W-1:0]   col_reg;
    logic [15:0]        row_reg;
    logic [1:0]         rm_reg;
    rgb_t               pix_reg;
    logic [7:0]         alpha_reg;
    rgb_t               v_reg;
    logic [2:0][8:0]    err_reg;
    logic [3:0]         tap_k_reg;
    logic [SLOT_AW-1:0] tap_addr_reg;
    logic [2:0][12:0]   prod_reg;
    logic               out_valid_reg;
    logic [7:0]         color_index_reg;
    rgb_t               out_col_reg;
    logic [7:0]         out_alpha_reg;
    logic               frame_end_reg;

    logic [2:0]         mode_reg;
    logic [10:0]        width_reg;
    logic [15:0]        height_reg;
    logic [8:0]         psize_reg;

    xform_t [2:0]       pend_mem [SLOTS];
    xform_t [2:0]       pend_q_reg;
    logic               pend_we;
    logic [SLOT_AW-1:0] pend_waddr;
    logic [SLOT_AW-1:0] pend_raddr;
    xform_t [2:0]       pend_wdata;

    mode_t              mode_eff;
    logic [10:0]        w_eff;
    logic [15:0]        h_eff;
    logic [8:0]         n_eff;
    rgb_t               v_next;
    tap_t               tp;
    logic signed [11:0] nx;
    logic [16:0]        ny;
    logic [2:0]         nm_sum;
    logic [1:0]         nm;
    logic               tap_active;
    logic               tap_in;
    logic [SLOT_AW-1:0] tap_ns;
    logic [2:0][12:0]   prod_next;
    logic               last_col;
    logic               last_row;
    logic               out_free;
    logic               in_acc;

    pal_wr_t            pal_wr;
    search_req_t        srch_req;
    search_res_t        srch_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NONE;
            width_reg  <= 11'(MAX_WIDTH);
            height_reg <= 16'd1;
            psize_reg  <= 9'(PALETTE_DEPTH);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MODE:   mode_reg   <= cfg_data[2:0];
                REG_WIDTH:  width_reg  <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data;
                REG_PSIZE:  psize_reg  <= cfg_data[8:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    assign mode_eff = (mode_reg > 3'(MODE_SIERRA_LITE)) ? MODE_NONE : mode_t'(mode_reg);
    assign w_eff    = (width_reg == 11'd0) ? 11'd1 :
                      (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;
    assign h_eff    = (height_reg == 16'd0) ? 16'd1 : height_reg;
    assign n_eff    = (psize_reg == 9'd0) ? 9'd1 :
                      (psize_reg > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : psize_reg;

    assign last_col = ({1'b0, col_reg} + 11'd1) >= w_eff;
    assign last_row = ({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff};

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            v_next[ch] = ped_apply(pix_reg[ch], pend_q_reg[ch]);
        end
    end

    // neighbour of the current tap
    always_comb
    begin
        tp         = ped_tap(mode_eff, tap_k_reg);
        tap_active = tap_k_reg < ped_tap_count(mode_eff);
        nx         = $signed({2'b00, col_reg}) + 12'(tp.dx);
        ny         = {1'b0, row_reg} + 17'(tp.dy);
        nm_sum     = 3'(rm_reg) + 3'(tp.dy);
        nm         = (nm_sum >= 3'(LOOKAHEAD)) ? 2'(nm_sum - 3'(LOOKAHEAD)) : nm_sum[1:0];
        tap_in     = !nx[11] && (nx[10:0] < w_eff) && (ny < {1'b0, h_eff});
        tap_ns     = {nm, nx[COL_W-1:0]};
        for (int ch = 0; ch < 3; ch++)
        begin
            prod_next[ch] = 13'($signed(err_reg[ch]) * $signed({1'b0, tp.w}));
        end
    end

    always_comb
    begin
        pend_we    = 1'b0;
        pend_waddr = {rm_reg, col_reg};
        pend_wdata = {XF_IDENT, XF_IDENT, XF_IDENT};
        pend_raddr = (state_reg == ST_TAP_RD) ? tap_ns : {rm_reg, col_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                pend_we    = 1'b1;
                pend_waddr = clr_addr_reg;
            end
            ST_APPLY:
            begin
                pend_we = 1'b1;
            end
            ST_TAP_WR:
            begin
                pend_we    = 1'b1;
                pend_waddr = tap_addr_reg;
                for (int ch = 0; ch < 3; ch++)
                begin
                    pend_wdata[ch] = ped_compose(pend_q_reg[ch],
                                                 ped_div(prod_reg[ch], mode_eff));
                end
            end
            default:
            begin
                pend_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pend_we)
        begin
            pend_mem[pend_waddr] <= pend_wdata;
        end
        pend_q_reg <= pend_mem[pend_raddr];
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign pal_wr.we    = in_acc && (op_t'(operation) == OP_LOAD);
    assign pal_wr.addr  = entry_index;
    assign pal_wr.color = {blue, green, red};

    assign srch_req.start  = (state_reg == ST_APPLY);
    assign srch_req.count  = n_eff;
    assign srch_req.target = v_next;

    ped_nearest u_nearest (
        .clk    (clk),
        .rst_n  (rst_n),
        .pal_wr (pal_wr),
        .req    (srch_req),
        .res    (srch_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            rm_reg          <= '0;
            pix_reg         <= '0;
            alpha_reg       <= '0;
            v_reg           <= '0;
            err_reg         <= '0;
            tap_k_reg       <= '0;
            tap_addr_reg    <= '0;
            prod_reg        <= '0;
            out_valid_reg   <= 1'b0;
            color_index_reg <= '0;
            out_col_reg     <= '0;
            out_alpha_reg   <= '0;
            frame_end_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_addr_reg == SLOT_AW'(SLOTS - 1))
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= ST_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc && op_t'(operation) == OP_PIXEL)
                    begin
                        pix_reg   <= {blue, green, red};
                        alpha_reg <= alpha;
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY:
                begin
                    v_reg     <= v_next;
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH:
                begin
                    if (srch_res.done)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        color_index_reg <= srch_res.index;
                        out_col_reg     <= srch_res.color;
                        out_alpha_reg   <= alpha_reg;
                        frame_end_reg   <= last_col && last_row;
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            err_reg[ch] <= {1'b0, v_reg[ch]} - {1'b0, srch_res.color[ch]};
                        end
                        tap_k_reg <= '0;
                        state_reg <= ST_TAP_RD;
                    end
                end
                ST_TAP_RD:
                begin
                    if (!tap_active)
                    begin
                        state_reg <= ST_ADVANCE;
                    end
                    else if (tap_in)
                    begin
                        tap_addr_reg <= tap_ns;
                        prod_reg     <= prod_next;
                        state_reg    <= ST_TAP_WR;
                    end
                    else
                    begin
                        tap_k_reg <= tap_k_reg + 4'd1;
                    end
                end
                ST_TAP_WR:
                begin
                    tap_k_reg <= tap_k_reg + 4'd1;
                    state_reg <= ST_TAP_RD;
                end
                ST_ADVANCE:
                begin
                    if (last_col)
                    begin
                        col_reg <= '0;
                        if (last_row)
                        begin
                            row_reg      <= '0;
                            rm_reg       <= '0;
                            clr_addr_reg <= '0;
                            state_reg    <= ST_CLEAR;
                        end
                        else
                        begin
                            row_reg   <= row_reg + 16'd1;
                            rm_reg    <= (rm_reg == 2'(LOOKAHEAD - 1)) ? 2'd0 : rm_reg + 2'd1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        col_reg   <= col_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign color_index = color_index_reg;
    assign out_red     = out_col_reg[0];
    assign out_green   = out_col_reg[1];
    assign out_blue    = out_col_reg[2];
    assign out_alpha   = out_alpha_reg;
    assign frame_end   = frame_end_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && op_t'(operation) == OP_PIXEL |=> state_reg == ST_APPLY)
        else $error("pixel item did not start its slot update");

    assert property (@(posedge clk) disable iff (!rst_n)
        srch_res.done |-> state_reg == ST_SEARCH)
        else $error("search finished outside the search step");

    assert property (@(posedge clk) disable iff (!rst_n)
        rm_reg != 2'd3)
        else $error("row ring index out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TAP_WR |-> tap_k_reg < 4'(NTAPS))
        else $error("tap counter past the kernel");

endmodule

// ----- design/ped_nearest.sv -----
// ----------------------------------------------------------------------------
// ped_nearest
// Palette store and nearest-colour search, one entry per cycle through a
// three-stage read / square / compare pipe.
// ----------------------------------------------------------------------------
module ped_nearest
    import ped_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pal_wr_t     pal_wr,
    input  search_req_t req,
    output search_res_t res
);

    typedef enum logic {
        SR_IDLE,
        SR_RUN
    } sr_state_t;

    sr_state_t         state_reg;
    logic [8:0]        issue_reg;
    logic [8:0]        count_reg;
    rgb_t              target_reg;
    logic              s1_vld_reg;
    logic [PAL_AW-1:0] s1_idx_reg;
    logic              s2_vld_reg;
    logic [PAL_AW-1:0] s2_idx_reg;
    rgb_t              s2_col_reg;
    logic [2:0][15:0]  sq_reg;
    logic [17:0]       best_d_reg;
    logic [PAL_AW-1:0] best_idx_reg;
    rgb_t              best_col_reg;
    logic              done_reg;

    rgb_t              pal_mem [PALETTE_DEPTH];
    rgb_t              pal_q_reg;

    logic              issue_go;
    logic [2:0][15:0]  sq_next;
    logic [17:0]       dsum;
    logic signed [8:0] diff;

    always_ff @(posedge clk)
    begin
        if (pal_wr.we)
        begin
            pal_mem[pal_wr.addr] <= pal_wr.color;
        end
        pal_q_reg <= pal_mem[issue_reg[PAL_AW-1:0]];
    end

    assign issue_go = (state_reg == SR_RUN) && (issue_reg < count_reg);

    always_comb
    begin
        sq_next = '0;
        diff    = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            diff        = $signed({1'b0, target_reg[ch]}) - $signed({1'b0, pal_q_reg[ch]});
            sq_next[ch] = 16'(diff * diff);
        end
    end

    assign dsum = 18'(sq_reg[0]) + 18'(sq_reg[1]) + 18'(sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SR_IDLE;
            issue_reg    <= '0;
            count_reg    <= '0;
            target_reg   <= '0;
            s1_vld_reg   <= 1'b0;
            s1_idx_reg   <= '0;
            s2_vld_reg   <= 1'b0;
            s2_idx_reg   <= '0;
            s2_col_reg   <= '0;
            sq_reg       <= '0;
            best_d_reg   <= '1;
            best_idx_reg <= '0;
            best_col_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                SR_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (req.start)
                    begin
                        state_reg    <= SR_RUN;
                        issue_reg    <= '0;
                        count_reg    <= req.count;
                        target_reg   <= req.target;
                        best_d_reg   <= '1;
                        best_idx_reg <= '0;
                    end
                end
                SR_RUN:
                begin
                    if (issue_go)
                    begin
                        issue_reg <= issue_reg + 9'd1;
                    end
                    s1_vld_reg <= issue_go;
                    s1_idx_reg <= issue_reg[PAL_AW-1:0];
                    s2_vld_reg <= s1_vld_reg;
                    s2_idx_reg <= s1_idx_reg;
                    s2_col_reg <= pal_q_reg;
                    sq_reg     <= sq_next;
                    if (s2_vld_reg && dsum < best_d_reg)
                    begin
                        best_d_reg   <= dsum;
                        best_idx_reg <= s2_idx_reg;
                        best_col_reg <= s2_col_reg;
                    end
                    done_reg <= !issue_go && !s1_vld_reg && !s2_vld_reg;
                    if (!issue_go && !s1_vld_reg && !s2_vld_reg)
                    begin
                        state_reg <= SR_IDLE;
                    end
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= SR_IDLE;
                end
            endcase
        end
    end

    assign res.done  = done_reg;
    assign res.index = best_idx_reg;
    assign res.color = best_col_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> state_reg == SR_RUN)
        else $error("compare stage active outside a search");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !s1_vld_reg && !s2_vld_reg)
        else $error("search done with entries still in the pipe");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SR_RUN |-> issue_reg <= count_reg)
        else $error("search issued past the palette size");

endmodule

// ----- test/palette_error_diffusion_dither_tb.sv -----
// ----------------------------------------------------------------------------
// palette_error_diffusion_dither_tb
// Self-checking bench for the palette error-diffusion ditherer. A scoreboard
// class mirrors palette, pending diffusion store and raster counters, predicts
// every pixel result and checks the output stream in order. Directed items hit
// channel extremes, ties and odd register values, then random frames run in
// every kernel under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_error_diffusion_dither_tb;
    import ped_pkg::*;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } pixel_result_t;

    class dither_scoreboard;
        int unsigned   mode;
        int unsigned   width;
        int unsigned   height;
        int unsigned   psize;
        int unsigned   palette [PALETTE_DEPTH];
        int            shift [3][SLOTS];
        int            lo [3][SLOTS];
        int            hi [3][SLOTS];
        int unsigned   col;
        int unsigned   row;
        int            divisor [7];
        pixel_result_t expected [$];
        int            mismatches;
        int            checked;
        int            frames;

        function new();
            divisor = '{1, 16, 8, 48, 32, 32, 4};
            mode = 0;
            width = 1024;
            height = 1;
            psize = 256;
            col = 0;
            row = 0;
            mismatches = 0;
            checked = 0;
            frames = 0;
            foreach (palette[i]) palette[i] = 0;
            clear_store();
        endfunction

        function void clear_store();
            for (int c = 0; c < 3; c++)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    shift[c][s] = 0;
                    lo[c][s] = 0;
                    hi[c][s] = 255;
                end
            end
        endfunction

        function int clip(int v, int l, int h);
            return v < l ? l : (v > h ? h : v);
        endfunction

        function void write_reg(reg_idx_t idx, logic [15:0] data);
            case (idx)
                REG_MODE:   mode = 32'(data & 16'h7);
                REG_WIDTH:  width = 32'(data & 16'h7ff);
                REG_HEIGHT: height = 32'(data);
                REG_PSIZE:  psize = 32'(data & 16'h1ff);
            endcase
        endfunction

        function void note_item(op_t op, logic [7:0] idx, logic [7:0] r,
                                logic [7:0] g, logic [7:0] b, logic [7:0] a);
            int unsigned   w, h, n, m, s, ns, best, bestd, d, p;
            int            v [3];
            int            pc [3];
            int            err [3];
            int            raw [3];
            int            nx, ny, dl, dc;
            tap_t          t;
            pixel_result_t res;
            raw = '{r, g, b};
            if (op == OP_LOAD)
            begin
                palette[idx] = {r, g, b};
                return;
            end
            w = width == 0 ? 1 : (width > MAX_WIDTH ? MAX_WIDTH : width);
            h = height == 0 ? 1 : height;
            n = psize == 0 ? 1 : (psize > PALETTE_DEPTH ? PALETTE_DEPTH : psize);
            m = mode > 6 ? 0 : mode;
            s = (row % LOOKAHEAD) * MAX_WIDTH + col;
            for (int c = 0; c < 3; c++)
            begin
                v[c] = clip(raw[c] + shift[c][s], lo[c][s], hi[c][s]);
                shift[c][s] = 0;
                lo[c][s] = 0;
                hi[c][s] = 255;
            end
            best = 0;
            bestd = 32'hffffffff;
            for (int i = 0; i < n; i++)
            begin
                p = palette[i];
                dl = v[0] - int'(p[23:16]);
                dc = v[1] - int'(p[15:8]);
                d = dl * dl + dc * dc + (v[2] - int'(p[7:0])) * (v[2] - int'(p[7:0]));
                if (d < bestd)
                begin
                    bestd = d;
                    best = i;
                end
            end
            p = palette[best];
            pc = '{p[23:16], p[15:8], p[7:0]};
            for (int c = 0; c < 3; c++) err[c] = v[c] - pc[c];
            for (int k = 0; k < TAP_COUNT[m]; k++)
            begin
                t = TAPS[m][k];
                nx = int'(col) + int'(t.dx);
                ny = int'(row) + int'(t.dy);
                if (nx < 0 || nx >= int'(w) || ny >= int'(h)) continue;
                ns = (ny % LOOKAHEAD) * MAX_WIDTH + nx;
                for (int c = 0; c < 3; c++)
                begin
                    dl = err[c] * int'(t.w) / divisor[m];
                    shift[c][ns] = clip(shift[c][ns] + dl, -256, 256);
                    lo[c][ns] = clip(lo[c][ns] + dl, 0, 255);
                    hi[c][ns] = clip(hi[c][ns] + dl, 0, 255);
                end
            end
            res.index = best[7:0];
            res.r = 8'(pc[0]);
            res.g = 8'(pc[1]);
            res.b = 8'(pc[2]);
            res.a = a;
            res.last = (col + 1 >= w && row + 1 >= h);
            expected.push_back(res);
            if (col + 1 >= w)
            begin
                col = 0;
                if (row + 1 >= h)
                begin
                    row = 0;
                    frames++;
                    clear_store();
                end
                else
                begin
                    row = row + 1;
                end
            end
            else
            begin
                col = col + 1;
            end
        endfunction

        function void check_result(pixel_result_t got);
            pixel_result_t want;
            checked++;
            if (expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result index %0d", $realtime, got.index);
                return;
            end
            want = expected.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch exp idx %0d rgba %0d %0d %0d %0d end %0d,",
                              " got idx %0d rgba %0d %0d %0d %0d end %0d"},
                             $realtime, want.index, want.r, want.g, want.b, want.a,
                             want.last, got.index, got.r, got.g, got.b, got.a, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  entry_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  color_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic        frame_end;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    dither_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int loaded;

    palette_error_diffusion_dither dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n || recv_stall_pct == 0)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{color_index, out_red, out_green, out_blue, out_alpha, frame_end});
    end

    task automatic send(op_t op, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [7:0] a);
        in_valid <= 1'b1;
        operation <= op;
        entry_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        alpha <= a;
        do @(posedge clk); while (in_stall);
        sb.note_item(op, idx, r, g, b, a);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic load(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send(OP_LOAD, idx, r, g, b, 8'($urandom()));
    endtask

    task automatic pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        send(OP_PIXEL, 8'($urandom()), r, g, b, a);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (3300) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic setup(mode_t m, logic [15:0] w, logic [15:0] h, logic [15:0] n);
        drain();
        write_reg(REG_MODE, 16'(m));
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PSIZE, n);
    endtask

    task automatic random_pixels(int count);
        for (int i = 0; i < count; i++)
            pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOAD;
        entry_index = '0;
        red = '0;
        green = '0;
        blue = '0;
        alpha = '0;
        cfg_write = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, a tied pair, every odd register value
        setup(MODE_FS, 16'd4, 16'd3, 16'd4);
        load(8'd0, 8'd0, 8'd0, 8'd0);
        load(8'd1, 8'd255, 8'd255, 8'd255);
        load(8'd2, 8'd128, 8'd0, 8'd255);
        load(8'd3, 8'd128, 8'd0, 8'd255);
        pixel(8'd0, 8'd0, 8'd0, 8'd0);
        pixel(8'd255, 8'd255, 8'd255, 8'd255);
        pixel(8'd128, 8'd0, 8'd255, 8'd1);
        pixel(8'd200, 8'd10, 8'd240, 8'd128);
        pixel(8'd255, 8'd0, 8'd0, 8'd127);
        pixel(8'd0, 8'd255, 8'd255, 8'd254);
        pixel(8'd64, 8'd64, 8'd64, 8'd85);
        pixel(8'd191, 8'd191, 8'd191, 8'd170);
        setup(mode_t'(7), 16'd0, 16'd0, 16'd0);
        random_pixels(3);
        setup(MODE_ATKINSON, 16'd2000, 16'd2, 16'd4);
        random_pixels(5);
        setup(MODE_ATKINSON, 16'd3, 16'd2, 16'd4);
        random_pixels(3);

        for (int i = 0; i < 256; i++)
            load(8'(i), 8'($urandom()), 8'($urandom()), 8'($urandom()));
        setup(MODE_JJN, 16'd5, 16'd2, 16'd511);
        random_pixels(4);
        drain();
        write_reg(REG_PSIZE, 16'd256);
        random_pixels(3);

        for (int ph = 0; ph < 12; ph++)
        begin
            setup(mode_t'(1 + ph % 6),
                  ph == 1 ? 16'd1024 : 16'($urandom_range(1, 12)),
                  ph == 0 ? 16'd65535 : 16'($urandom_range(1, 5)),
                  ph == 2 ? 16'd256 : 16'($urandom_range(1, 40)));
            send_idle_pct  = (ph % 4 == 1) ? 80 : (ph % 4 == 3 ? 26 : 0);
            recv_stall_pct = (ph % 4 == 2) ? 80 : (ph % 4 == 3 ? 26 : 0);
            for (int i = 0; i < 10; i++)
            begin
                if (ph == 5 && i == 5)
                begin
                    in_valid <= 1'b0;
                    while (sb.expected.size() != 0) @(posedge clk);
                    @(posedge clk);
                end
                if ($urandom_range(9) == 0)
                    load(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
                else
                    pixel(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()));
            end
        end

        in_valid <= 1'b0;
        while (sb.expected.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("covered %0d pixel results over %0d completed frames, all kernels",
                 sb.checked, sb.frames);
        $display("with odd register values and sender and receiver idling");
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
